/* rtl/acs_pkg.sv */
`default_nettype none
package acs_pkg;

   localparam int unsigned SeriesTermsDefault = 11;
   localparam int unsigned XWidth = 32;
   localparam int unsigned QWidth = 31;
   localparam int unsigned AccWidth = 33;
   localparam int unsigned AngleWidth = 32;
   localparam int unsigned FracShift = 30;
   localparam int unsigned DivShift = 14;
   localparam logic [QWidth-1:0] HalfPiQ30 = 31'd1686629713;
   localparam logic [XWidth-1:0] OneQ16 = 32'd65536;

   typedef struct packed {
      logic neg;
      logic small_arg;
   } acs_meta_type;

endpackage
`default_nettype wire

/* rtl/acs_div.sv */
`default_nettype none
module acs_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic [acs_pkg::XWidth-1:0]  in_x,
   input  wire acs_pkg::acs_meta_type       in_meta,
   output logic                             out_valid,
   output logic [acs_pkg::XWidth-1:0]       out_x,
   output logic [acs_pkg::QWidth-1:0]       out_q,
   output acs_pkg::acs_meta_type            out_meta
);
   import acs_pkg::*;

   localparam int unsigned Steps = QWidth;

   logic                 valid_ff [0:Steps];
   logic [XWidth-1:0]    x_ff     [0:Steps];
   logic [QWidth-1:0]    rem_ff   [0:Steps];
   logic [QWidth-1:0]    q_ff     [0:Steps];
   acs_meta_type         meta_ff  [0:Steps];

   always_comb begin
      valid_ff[0] = in_valid;
      x_ff[0]     = in_x;
      rem_ff[0]   = QWidth'(32'd1 << 15);
      q_ff[0]     = '0;
      meta_ff[0]  = in_meta;
   end

   for (genvar j = 0; j < Steps; j++) begin : g_step
      logic [XWidth-1:0] sh_in;
      logic [XWidth-1:0] diff_in;
      logic              take_in;

      always_comb begin
         sh_in   = {rem_ff[j], 1'b0};
         diff_in = sh_in - x_ff[j];
         take_in = (sh_in >= x_ff[j]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+1] <= 1'b0;
         end else begin
            valid_ff[j+1] <= valid_ff[j];
         end
         x_ff[j+1]    <= x_ff[j];
         meta_ff[j+1] <= meta_ff[j];
         rem_ff[j+1]  <= take_in ? diff_in[QWidth-1:0] : sh_in[QWidth-1:0];
         q_ff[j+1]    <= {q_ff[j][QWidth-2:0], take_in};
      end
   end

   assign out_valid = valid_ff[Steps];
   assign out_x     = x_ff[Steps];
   assign out_q     = q_ff[Steps];
   assign out_meta  = meta_ff[Steps];

endmodule
`default_nettype wire

/* rtl/acs_term.sv */
`default_nettype none
module acs_term #(
   parameter int unsigned K = 0
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   input  wire logic [acs_pkg::QWidth-1:0]          in_p,
   input  wire logic [acs_pkg::QWidth-1:0]          in_u2,
   input  wire logic signed [acs_pkg::AccWidth-1:0] in_acc,
   input  wire acs_pkg::acs_meta_type               in_meta,
   output logic                                     out_valid,
   output logic [acs_pkg::QWidth-1:0]               out_p,
   output logic [acs_pkg::QWidth-1:0]               out_u2,
   output logic signed [acs_pkg::AccWidth-1:0]      out_acc,
   output acs_pkg::acs_meta_type                    out_meta
);
   import acs_pkg::*;

   localparam logic [6:0]  Divisor = 7'(2 * K + 1);
   localparam logic [32:0] Recip = 33'((64'd1 << 32) / (2 * K + 1));

   logic                       a_valid_ff, b_valid_ff, c_valid_ff;
   logic [2*QWidth-1:0]        a_prod_ff;
   logic [QWidth+32:0]         a_recip_ff;
   logic [QWidth-1:0]          a_p_ff, a_u2_ff, b_p_ff, b_u2_ff, b_pn_ff, b_q0_ff;
   logic [QWidth-1:0]          c_pn_ff, c_u2_ff;
   logic signed [AccWidth-1:0] a_acc_ff, b_acc_ff, c_acc_ff;
   acs_meta_type               a_meta_ff, b_meta_ff, c_meta_ff;
   logic [QWidth+6:0]          back_in;
   logic [QWidth+6:0]          rem_in;
   logic [QWidth-1:0]          q_in;
   logic signed [AccWidth-1:0] acc_in;

   always_comb begin
      back_in = (QWidth + 7)'(b_q0_ff) * (QWidth + 7)'(Divisor);
      rem_in  = (QWidth + 7)'(b_p_ff) - back_in;
      q_in    = b_q0_ff + QWidth'(rem_in >= (QWidth + 7)'(Divisor));
      if (K % 2 == 0) begin
         acc_in = b_acc_ff + AccWidth'(signed'({1'b0, q_in}));
      end else begin
         acc_in = b_acc_ff - AccWidth'(signed'({1'b0, q_in}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
      a_prod_ff  <= (2 * QWidth)'(in_p) * (2 * QWidth)'(in_u2);
      a_recip_ff <= (QWidth + 33)'(in_p) * (QWidth + 33)'(Recip);
      a_p_ff     <= in_p;
      a_u2_ff    <= in_u2;
      a_acc_ff   <= in_acc;
      a_meta_ff  <= in_meta;
      b_pn_ff    <= a_prod_ff[FracShift +: QWidth];
      b_q0_ff    <= a_recip_ff[32 +: QWidth];
      b_p_ff     <= a_p_ff;
      b_u2_ff    <= a_u2_ff;
      b_acc_ff   <= a_acc_ff;
      b_meta_ff  <= a_meta_ff;
      c_pn_ff    <= b_pn_ff;
      c_u2_ff    <= b_u2_ff;
      c_acc_ff   <= acc_in;
      c_meta_ff  <= b_meta_ff;
   end

   assign out_valid = c_valid_ff;
   assign out_p     = c_pn_ff;
   assign out_u2    = c_u2_ff;
   assign out_acc   = c_acc_ff;
   assign out_meta  = c_meta_ff;

endmodule
`default_nettype wire

/* rtl/arccot_series_unit.sv */
`default_nettype none
// Arccotangent unit: angle = arccot(req_x_value), signed Q15.16 in, unsigned Q2.30 out.
// Input channel: a beat is taken at a rising edge with start high and busy low.
// busy is held low, so one argument may enter in every cycle.
// Result channel: rsp_strobe is high for one cycle with rsp_angle and rsp_in_range;
// the receiver takes the beat in that cycle and cannot stall the unit.
// Results leave in the order the arguments came.
// Pipeline from the accepting edge to the edge that takes the result: one input
// register, a 31-stage restoring divider for 1/x, one squaring stage, three stages
// per series term (power product with reciprocal multiply, product truncation,
// remainder fix and accumulate), and one output register.
// Throughput: one beat per cycle, set by the fully pipelined divider and terms.
// A negative argument gives angle 0 with rsp_in_range low.
// Reset clears every valid bit; beats in flight are dropped.
module arccot_series_unit #(
   parameter int unsigned SERIES_TERMS = acs_pkg::SeriesTermsDefault
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [acs_pkg::XWidth-1:0]      req_x_value,
   output logic                                 rsp_strobe,
   output logic [acs_pkg::AngleWidth-1:0]       rsp_angle,
   output logic                                 rsp_in_range
);
   import acs_pkg::*;

   logic                       in_valid_ff;
   logic [XWidth-1:0]          in_x_ff;
   acs_meta_type               in_meta_ff;
   logic                       dv_valid;
   logic [XWidth-1:0]          dv_x;
   logic [QWidth-1:0]          dv_q;
   acs_meta_type               dv_meta;
   logic [QWidth-1:0]          u_in;
   logic [2*QWidth-1:0]        sq_in;
   logic                       sq_valid_ff;
   logic [QWidth-1:0]          sq_u_ff, sq_u2_ff;
   acs_meta_type               sq_meta_ff;
   logic                       t_valid [0:SERIES_TERMS];
   logic [QWidth-1:0]          t_p     [0:SERIES_TERMS];
   logic [QWidth-1:0]          t_u2    [0:SERIES_TERMS];
   logic signed [AccWidth-1:0] t_acc   [0:SERIES_TERMS];
   acs_meta_type               t_meta  [0:SERIES_TERMS];
   logic signed [AccWidth:0]   res_in;
   logic [AngleWidth-1:0]      angle_in;
   logic                       out_valid_ff;
   logic [AngleWidth-1:0]      out_angle_ff;
   logic                       out_range_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
      in_x_ff              <= req_x_value;
      in_meta_ff.neg       <= req_x_value[XWidth-1];
      in_meta_ff.small_arg <= (req_x_value < OneQ16);
   end

   acs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_x      (in_x_ff),
      .in_meta   (in_meta_ff),
      .out_valid (dv_valid),
      .out_x     (dv_x),
      .out_q     (dv_q),
      .out_meta  (dv_meta)
   );

   always_comb begin
      u_in  = dv_meta.small_arg ? QWidth'({dv_x[16:0], DivShift'(0)}) : dv_q;
      sq_in = (2 * QWidth)'(u_in) * (2 * QWidth)'(u_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= dv_valid;
      end
      sq_u_ff    <= u_in;
      sq_u2_ff   <= sq_in[FracShift +: QWidth];
      sq_meta_ff <= dv_meta;
   end

   always_comb begin
      t_valid[0] = sq_valid_ff;
      t_p[0]     = sq_u_ff;
      t_u2[0]    = sq_u2_ff;
      t_acc[0]   = '0;
      t_meta[0]  = sq_meta_ff;
   end

   for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_term
      acs_term #(.K(k)) u_term (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (t_valid[k]),
         .in_p      (t_p[k]),
         .in_u2     (t_u2[k]),
         .in_acc    (t_acc[k]),
         .in_meta   (t_meta[k]),
         .out_valid (t_valid[k+1]),
         .out_p     (t_p[k+1]),
         .out_u2    (t_u2[k+1]),
         .out_acc   (t_acc[k+1]),
         .out_meta  (t_meta[k+1])
      );
   end

   always_comb begin
      if (t_meta[SERIES_TERMS].small_arg) begin
         res_in = (AccWidth + 1)'(signed'({1'b0, HalfPiQ30}))
                - (AccWidth + 1)'(t_acc[SERIES_TERMS]);
      end else begin
         res_in = (AccWidth + 1)'(t_acc[SERIES_TERMS]);
      end
      if (res_in < 0) begin
         angle_in = '0;
      end else if (res_in > (AccWidth + 1)'(signed'({2'b00, {AngleWidth{1'b1}}}))) begin
         angle_in = '1;
      end else begin
         angle_in = res_in[AngleWidth-1:0];
      end
      if (t_meta[SERIES_TERMS].neg) begin
         angle_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= t_valid[SERIES_TERMS];
      end
      out_angle_ff <= angle_in;
      out_range_ff <= ~t_meta[SERIES_TERMS].neg;
   end

   assign rsp_strobe   = out_valid_ff;
   assign rsp_angle    = out_angle_ff;
   assign rsp_in_range = out_range_ff;

endmodule
`default_nettype wire

/* tb/sv/arccot_series_unit_test.sv */
`default_nettype none
module arccot_series_unit_test;
   import acs_pkg::*;

   localparam int unsigned Terms = SeriesTermsDefault;
   localparam int unsigned Latency = 3 * Terms + 34;
   localparam int unsigned RandomBeats = 1030;
   localparam longint unsigned CycleLimit = 200000;
   localparam longint unsigned OneQ30 = 64'd1 << 30;

   typedef struct {
      logic [XWidth-1:0] x;
      logic              known;
      logic [AngleWidth-1:0] angle;
      logic              in_range;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [XWidth-1:0] req_x_value = '0;
   wire logic busy;
   wire logic rsp_strobe;
   wire logic [AngleWidth-1:0] rsp_angle;
   wire logic rsp_in_range;

   logic [AngleWidth-1:0] angle_queue[$];
   logic in_range_queue[$];
   int unsigned errors = 0;
   int unsigned beats_sent = 0;
   int unsigned beats_checked = 0;
   int unsigned negative_sent = 0;
   int unsigned large_sent = 0;
   longint unsigned cycle_count = 0;
   stim_row_type table_rows[$];

   arccot_series_unit #(.SERIES_TERMS(Terms)) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_x_value(req_x_value),
      .rsp_strobe(rsp_strobe),
      .rsp_angle(rsp_angle),
      .rsp_in_range(rsp_in_range)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint signed alternating_sum(longint unsigned u);
      longint unsigned u2;
      longint unsigned p;
      longint signed acc;
      u2 = (u * u) >> FracShift;
      p = u;
      acc = 0;
      for (int unsigned k = 0; k < Terms; k++) begin
         if (k % 2 == 0) acc += longint'(p / (2 * k + 1));
         else acc -= longint'(p / (2 * k + 1));
         p = (p * u2) >> FracShift;
      end
      return acc;
   endfunction

   task automatic predict_arccot(input logic [XWidth-1:0] x, output logic [AngleWidth-1:0] angle,
                                 output logic in_range);
      longint unsigned u;
      longint signed res;
      if (x[XWidth-1]) begin
         angle = '0;
         in_range = 1'b0;
      end else begin
         if (x < OneQ16) begin
            u = longint'(x) << DivShift;
            res = longint'(HalfPiQ30) - alternating_sum(u);
         end else begin
            u = (64'd1 << 46) / longint'(x);
            if (u > OneQ30) u = OneQ30;
            res = alternating_sum(u);
         end
         if (res < 0) res = 0;
         if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
         angle = res[AngleWidth-1:0];
         in_range = 1'b1;
      end
   endtask

   function automatic logic [XWidth-1:0] random_x();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1: return {1'b1, 31'($urandom)};
         2, 3, 4: return 32'($urandom_range(0, OneQ16 - 1));
         5: return OneQ16 + 32'($urandom_range(0, 255)) - 32'd128;
         6: return 32'($urandom_range(OneQ16, 32'h00FF_FFFF));
         default: return {1'b0, 31'($urandom)};
      endcase
   endfunction

   task automatic send_beat(input logic [XWidth-1:0] x, input logic known,
                            input logic [AngleWidth-1:0] angle, input logic in_range);
      logic [AngleWidth-1:0] angle_p;
      logic in_range_p;
      start <= 1'b1;
      req_x_value <= x;
      do @(posedge clock); while (busy);
      predict_arccot(x, angle_p, in_range_p);
      if (known && (angle_p !== angle || in_range_p !== in_range)) begin
         $display("%0t table row x=%h expected %h/%b predicted %h/%b", $time, x, angle,
                  in_range, angle_p, in_range_p);
         errors++;
      end
      angle_queue.push_back(known ? angle : angle_p);
      in_range_queue.push_back(known ? in_range : in_range_p);
      beats_sent++;
      if (x[XWidth-1]) negative_sent++;
      else if (x >= OneQ16) large_sent++;
   endtask

   task automatic pause_sender(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_strobe) begin
         if (angle_queue.size() == 0) begin
            $display("%0t unexpected beat angle=%h in_range=%b", $time, rsp_angle,
                     rsp_in_range);
            errors++;
         end else begin
            if (rsp_angle !== angle_queue[0] || rsp_in_range !== in_range_queue[0]) begin
               $display("%0t mismatch expected angle=%h in_range=%b actual angle=%h in_range=%b",
                        $time, angle_queue[0], in_range_queue[0], rsp_angle, rsp_in_range);
               errors++;
            end
            void'(angle_queue.pop_front());
            void'(in_range_queue.pop_front());
            beats_checked++;
         end
      end
      if (cycle_count >= CycleLimit) begin
         $display("%0t timeout with %0d beats outstanding", $time, angle_queue.size());
         $display("FAILURE");
         $finish;
      end
   end

   function automatic stim_row_type row(logic [XWidth-1:0] x, logic known,
                                        logic [AngleWidth-1:0] angle, logic in_range);
      stim_row_type r;
      r.x = x;
      r.known = known;
      r.angle = angle;
      r.in_range = in_range;
      return r;
   endfunction

   initial begin
      int unsigned burst;
      table_rows.push_back(row(32'h0000_0000, 1'b1, 32'(HalfPiQ30), 1'b1));
      table_rows.push_back(row(32'h8000_0000, 1'b1, 32'd0, 1'b0));
      table_rows.push_back(row(32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0));
      table_rows.push_back(row(32'hFFFF_0000, 1'b1, 32'd0, 1'b0));
      table_rows.push_back(row(32'h7FFF_FFFF, 1'b1, 32'd32768, 1'b1));
      table_rows.push_back(row(32'h4000_0000, 1'b1, 32'd65536, 1'b1));
      table_rows.push_back(row(32'h0000_0001, 1'b0, '0, 1'b0));
      table_rows.push_back(row(32'h0000_FFFF, 1'b0, '0, 1'b0));
      table_rows.push_back(row(OneQ16, 1'b0, '0, 1'b0));
      table_rows.push_back(row(OneQ16 + 1, 1'b0, '0, 1'b0));
      table_rows.push_back(row(32'h0000_8000, 1'b0, '0, 1'b0));
      table_rows.push_back(row(32'h0002_0000, 1'b0, '0, 1'b0));
      table_rows.push_back(row(32'h0001_8000, 1'b0, '0, 1'b0));
      table_rows.push_back(row(32'h0040_0000, 1'b0, '0, 1'b0));
      table_rows.push_back(row(32'h5555_5555, 1'b0, '0, 1'b0));
      table_rows.push_back(row(32'h2AAA_AAAA, 1'b0, '0, 1'b0));
      table_rows.push_back(row(32'hAAAA_AAAA, 1'b1, 32'd0, 1'b0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i]) begin
         send_beat(table_rows[i].x, table_rows[i].known, table_rows[i].angle,
                   table_rows[i].in_range);
         if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 3));
      end

      // hold off until the pipe has drained once
      start <= 1'b0;
      while (angle_queue.size() != 0) @(posedge clock);

      while (beats_sent < table_rows.size() + RandomBeats) begin
         burst = $urandom_range(1, 40);
         repeat (burst) send_beat(random_x(), 1'b0, '0, 1'b0);
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, Latency + 10));
      end
      start <= 1'b0;

      while (angle_queue.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);

      $display("%0d arguments sent (%0d negative, %0d at or above one), %0d beats checked",
               beats_sent, negative_sent, large_sent, beats_checked);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d errors", errors);
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
rtl/acs_pkg.sv
rtl/acs_div.sv
rtl/acs_term.sv
rtl/arccot_series_unit.sv
tb/sv/arccot_series_unit_test.sv
